/* hw/rtl/pmq_pkg.sv */
// pmq_pkg: shared types, codes and reset constants of the priority message queue
// used by pmq_ctrl, pmq_dp and priority_message_queue
package pmq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int CNT_W         = 5;
  localparam int CFG_W         = 16;

  localparam logic [1:0] OP_SEND  = 2'd0;
  localparam logic [1:0] OP_RECV  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SIZE  = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  localparam logic       REG_MAX_MESSAGES = 1'b0;
  localparam logic       REG_SIZE_LIMIT   = 1'b1;

  localparam logic [CNT_W-1:0] RESET_MAX_MESSAGES = 5'd10;
  localparam logic [15:0]      RESET_SIZE_LIMIT   = 16'd8192;

  typedef struct packed {
    logic [31:0] payload;
    logic [15:0] length;
    logic [15:0] prio;
  } entry_t;

  typedef struct packed {
    logic       load;
    logic       commit;
    logic       insert;
    logic       pop;
    logic [1:0] code;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       too_long;
    logic       too_short;
    logic       full;
    logic       empty;
  } dp_status_t;

endpackage

/* hw/rtl/pmq_ctrl.sv */
// pmq_ctrl: sequencer of the priority message queue, decides each item's outcome
// depends on pmq_pkg
module pmq_ctrl
  import pmq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  dp_status_t dp_status,
  output dp_cmd_t    dp_cmd,
  output logic       busy
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    dp_cmd     = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          dp_cmd.load = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        dp_cmd.commit = 1'b1;
        dp_cmd.code   = ST_OK;
        unique case (dp_status.op)
          OP_SEND: begin
            if (dp_status.too_long) begin
              dp_cmd.code = ST_SIZE;
            end else if (dp_status.full) begin
              dp_cmd.code = ST_FULL;
            end else begin
              dp_cmd.insert = 1'b1;
            end
          end
          OP_RECV: begin
            if (dp_status.too_short) begin
              dp_cmd.code = ST_SIZE;
            end else if (dp_status.empty) begin
              dp_cmd.code = ST_EMPTY;
            end else begin
              dp_cmd.pop = 1'b1;
            end
          end
          default: begin
            dp_cmd.code = ST_OK;
          end
        endcase
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state == S_EXEC);

endmodule

/* hw/rtl/pmq_dp.sv */
// pmq_dp: operand latch, config registers, sorted shift-register entry cells, result regs
// depends on pmq_pkg
module pmq_dp
  import pmq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  dp_cmd_t          dp_cmd,
  output dp_status_t       dp_status,
  input  logic [1:0]       operation,
  input  logic [15:0]      priority_req,
  input  logic [15:0]      message_length,
  input  logic [31:0]      payload_word,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output logic             done,
  output logic [1:0]       status,
  output logic [31:0]      out_payload,
  output logic [15:0]      out_length,
  output logic [15:0]      out_priority,
  output logic [CNT_W-1:0] entry_count
);

  logic [1:0]       op_r;
  logic [15:0]      prio_r;
  logic [15:0]      len_r;
  logic [31:0]      payload_r;
  logic [CNT_W-1:0] max_messages;
  logic [15:0]      size_limit;
  logic [CNT_W-1:0] count;
  entry_t           cells [DEPTH];
  entry_t           new_entry;
  logic [DEPTH-1:0] ge;

  // operand latch
  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      op_r      <= operation;
      prio_r    <= priority_req;
      len_r     <= message_length;
      payload_r <= payload_word;
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_messages <= RESET_MAX_MESSAGES;
      size_limit   <= RESET_SIZE_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_MESSAGES: max_messages <= cfg_data[CNT_W-1:0];
        REG_SIZE_LIMIT:   size_limit   <= cfg_data[15:0];
        default:          size_limit   <= size_limit;
      endcase
    end
  end

  assign dp_status.op        = op_r;
  assign dp_status.too_long  = (len_r > size_limit);
  assign dp_status.too_short = (len_r < size_limit);
  assign dp_status.full      = (count >= max_messages) || (int'(count) >= DEPTH);
  assign dp_status.empty     = (count == '0);

  assign new_entry = '{payload: payload_r, length: len_r, prio: prio_r};

  // cells holding an entry of equal or higher priority form a prefix
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ge[i] = (int'(count) > i) && (cells[i].prio >= prio_r);
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    always_ff @(posedge clk) begin
      if (dp_cmd.insert) begin
        if (!ge[g]) begin
          if (g == 0) begin
            cells[g] <= new_entry;
          end else if (ge[(g == 0) ? 0 : g-1]) begin
            cells[g] <= new_entry;
          end else begin
            cells[g] <= cells[(g == 0) ? 0 : g-1];
          end
        end
      end else if (dp_cmd.pop) begin
        if (g < DEPTH-1) begin
          cells[g] <= cells[(g < DEPTH-1) ? g+1 : g];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= dp_cmd.commit;
      if (dp_cmd.insert) begin
        count <= count + 1'b1;
      end else if (dp_cmd.pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.commit) begin
      status <= dp_cmd.code;
      if (dp_cmd.pop) begin
        out_payload  <= cells[0].payload;
        out_length   <= cells[0].length;
        out_priority <= cells[0].prio;
      end else begin
        out_payload  <= '0;
        out_length   <= '0;
        out_priority <= '0;
      end
    end
  end

  assign entry_count = count;

endmodule

/* hw/rtl/priority_message_queue.sv */
// priority_message_queue: top level of the bounded priority message queue
// depends on pmq_pkg, pmq_ctrl and pmq_dp
//
// usage:
//   an item (operation, priority_req, message_length, payload_word) is taken at a
//   rising edge with start high and busy low. operation 0 sends, 1 receives the
//   highest priority entry (first in first out within a priority), 2 returns the count.
//   the result (status, out_payload, out_length, out_priority, entry_count) is shown
//   for one cycle with done high, from the edge after the accepting edge.
//   busy is high after acceptance, for the single execute step of the
//   controller, and no new item is taken while busy is high. entries sit in a sorted
//   row of shift-register cells; an insert shifts all cells behind the new entry and a
//   pop shifts the row to the head, in the execute step. configuration: cfg_we writes
//   cfg_data to register cfg_index (0 max_messages, 1 message_size_limit) at the edge;
//   the user writes only while the queue is idle, the block does not enforce it. reset
//   (rst, synchronous) empties the queue and restores max_messages 10 and
//   message_size_limit 8192. the receiver cannot stall: done is a one-cycle strobe.
module priority_message_queue
  import pmq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       operation,
  input  logic [15:0]      priority_req,
  input  logic [15:0]      message_length,
  input  logic [31:0]      payload_word,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output logic             done,
  output logic [1:0]       status,
  output logic [31:0]      out_payload,
  output logic [15:0]      out_length,
  output logic [15:0]      out_priority,
  output logic [CNT_W-1:0] entry_count
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  pmq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .dp_status (dp_status),
    .dp_cmd    (dp_cmd),
    .busy      (busy)
  );

  pmq_dp #(
    .DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .dp_cmd         (dp_cmd),
    .dp_status      (dp_status),
    .operation      (operation),
    .priority_req   (priority_req),
    .message_length (message_length),
    .payload_word   (payload_word),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .done           (done),
    .status         (status),
    .out_payload    (out_payload),
    .out_length     (out_length),
    .out_priority   (out_priority),
    .entry_count    (entry_count)
  );

`ifndef ASSERT_OFF
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("done without a preceding execute cycle");

  a_busy_one_cycle: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("busy held longer than one cycle");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_EMPTY) |-> (entry_count == '0))
    else $error("empty status with entries held");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (out_payload == '0 && out_length == '0 &&
                                   out_priority == '0))
    else $error("rejected item carries message data");
`endif

endmodule

/* sim/priority_message_queue_checker.sv */
// priority_message_queue_checker: tracks the queue contents and registers of the block,
// predicts each result and compares it field by field with the done strobe
// depends on pmq_pkg
module priority_message_queue_checker
  import pmq_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  logic [1:0]       operation,
  input  logic [15:0]      priority_req,
  input  logic [15:0]      message_length,
  input  logic [31:0]      payload_word,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             done,
  input  logic [1:0]       status,
  input  logic [31:0]      out_payload,
  input  logic [15:0]      out_length,
  input  logic [15:0]      out_priority,
  input  logic [CNT_W-1:0] entry_count,
  output int               errors,
  output int               pending
);

  typedef struct packed {
    logic [1:0]       status;
    logic [31:0]      payload;
    logic [15:0]      length;
    logic [15:0]      prio;
    logic [CNT_W-1:0] count;
  } reply_t;

  entry_t           held [DEPTH_DEFAULT];
  int               held_total;
  logic [CNT_W-1:0] max_messages_q;
  logic [15:0]      size_limit_q;
  reply_t           replies_due [$];
  reply_t           want;

  initial begin
    errors = 0;
    pending = 0;
    held_total = 0;
  end

  function automatic reply_t queue_reply(input logic [1:0] op, input logic [15:0] prio,
                                         input logic [15:0] len, input logic [31:0] word);
    reply_t r;
    int     lim;
    int     pos;
    r = '0;
    r.status = ST_OK;
    lim = (int'(max_messages_q) > DEPTH_DEFAULT) ? DEPTH_DEFAULT : int'(max_messages_q);
    case (op)
      OP_SEND: begin
        if (len > size_limit_q) begin
          r.status = ST_SIZE;
        end else if (held_total >= lim) begin
          r.status = ST_FULL;
        end else begin
          // goes behind every entry of equal or higher priority
          pos = held_total;
          while (pos > 0 && held[pos-1].prio < prio) begin
            held[pos] = held[pos-1];
            pos--;
          end
          held[pos] = {word, len, prio};
          held_total++;
        end
      end
      OP_RECV: begin
        if (len < size_limit_q) begin
          r.status = ST_SIZE;
        end else if (held_total == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.payload = held[0].payload;
          r.length = held[0].length;
          r.prio = held[0].prio;
          for (int j = 1; j < held_total; j++) held[j-1] = held[j];
          held_total--;
        end
      end
      default: ;
    endcase
    r.count = held_total[CNT_W-1:0];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] expected,
                             input logic [31:0] actual);
    if (actual !== expected) begin
      $display("%0t: %s expected %0h got %0h", $time, name, expected, actual);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      held_total = 0;
      max_messages_q = RESET_MAX_MESSAGES;
      size_limit_q = RESET_SIZE_LIMIT;
      replies_due.delete();
    end else begin
      if (done) begin
        if (replies_due.size() == 0) begin
          $display("%0t: result with no item pending, status %0d", $time, status);
          errors++;
        end else begin
          want = replies_due.pop_front();
          check_field("status", 32'(want.status), 32'(status));
          check_field("out_payload", want.payload, out_payload);
          check_field("out_length", 32'(want.length), 32'(out_length));
          check_field("out_priority", 32'(want.prio), 32'(out_priority));
          check_field("entry_count", 32'(want.count), 32'(entry_count));
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_MAX_MESSAGES) max_messages_q = cfg_data[CNT_W-1:0];
        else size_limit_q = cfg_data;
      end
      if (start && !busy)
        replies_due.push_back(queue_reply(operation, priority_req, message_length,
                                          payload_word));
    end
    pending = replies_due.size();
  end

endmodule

/* sim/priority_message_queue_tb.sv */
// priority_message_queue_tb: drives sends, receives and queries into the queue,
// rewrites its registers between phases and gives the verdict
// depends on pmq_pkg, priority_message_queue and priority_message_queue_checker
module priority_message_queue_tb;
  import pmq_pkg::*;

  localparam int         RUN_LIMIT = 400000;
  localparam logic [1:0] OP_SPARE  = 2'd3;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  logic [1:0]       operation = OP_QUERY;
  logic [15:0]      priority_req = '0;
  logic [15:0]      message_length = '0;
  logic [31:0]      payload_word = '0;
  logic             cfg_we = 1'b0;
  logic             cfg_index = REG_MAX_MESSAGES;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             done;
  logic [1:0]       status;
  logic [31:0]      out_payload;
  logic [15:0]      out_length;
  logic [15:0]      out_priority;
  logic [CNT_W-1:0] entry_count;
  int               errors;
  int               pending;
  bit               gaps_on = 1'b1;
  logic [15:0]      size_limit_now = RESET_SIZE_LIMIT;

  priority_message_queue uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .priority_req(priority_req),
    .message_length(message_length), .payload_word(payload_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .status(status), .out_payload(out_payload),
    .out_length(out_length), .out_priority(out_priority), .entry_count(entry_count)
  );

  priority_message_queue_checker queue_check (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .priority_req(priority_req),
    .message_length(message_length), .payload_word(payload_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .status(status), .out_payload(out_payload),
    .out_length(out_length), .out_priority(out_priority), .entry_count(entry_count),
    .errors(errors), .pending(pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  task automatic issue(input logic [1:0] op, input logic [15:0] prio,
                       input logic [15:0] len, input logic [31:0] word);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    operation <= op;
    priority_req <= prio;
    message_length <= len;
    payload_word <= word;
    do @(negedge clk); while (busy);
    @(posedge clk);
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0 || busy);
    repeat (2) @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_W-1:0] max_word, input logic [CFG_W-1:0] limit);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= REG_MAX_MESSAGES;
    cfg_data <= max_word;
    @(posedge clk);
    cfg_index <= REG_SIZE_LIMIT;
    cfg_data <= limit;
    @(posedge clk);
    cfg_we <= 1'b0;
    size_limit_now = limit;
  endtask

  task automatic random_item(input int send_weight);
    logic [1:0]  op;
    logic [15:0] prio;
    logic [15:0] len;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < send_weight) op = OP_SEND;
    else if (pick < 92) op = OP_RECV;
    else if (pick < 97) op = OP_QUERY;
    else op = OP_SPARE;
    // few distinct priorities exercise the in-order rule within one level
    prio = $urandom_range(0, 1) ? 16'($urandom_range(0, 3)) : 16'($urandom_range(0, 65535));
    if ($urandom_range(0, 9) == 0) len = 16'($urandom_range(0, 65535));
    else if (op == OP_SEND) len = 16'($urandom_range(0, size_limit_now));
    else len = 16'($urandom_range(size_limit_now, 65535));
    issue(op, prio, len, $urandom());
  endtask

  initial begin
    logic [CFG_W-1:0] max_word;
    logic [CFG_W-1:0] limit;
    int               send_weight;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // tiny queue: empty, size errors, full, check order, priority order
    configure(16'd3, 16'd100);
    issue(OP_RECV, 16'd0, 16'd100, 32'd0);
    issue(OP_RECV, 16'd0, 16'd99, 32'd0);
    issue(OP_QUERY, 16'd0, 16'd0, 32'd0);
    issue(OP_SEND, 16'd7, 16'd101, 32'h1234_5678);
    issue(OP_SEND, 16'd0, 16'd100, 32'h0000_0000);
    issue(OP_SEND, 16'hffff, 16'd0, 32'hffff_ffff);
    issue(OP_SEND, 16'hffff, 16'd1, 32'h5a5a_a5a5);
    issue(OP_SEND, 16'h8000, 16'd2, 32'h0f0f_f0f0);
    issue(OP_SEND, 16'h8000, 16'd101, 32'h0f0f_f0f0);
    issue(OP_SPARE, 16'hffff, 16'hffff, 32'hffff_ffff);
    issue(OP_RECV, 16'hffff, 16'hffff, 32'hffff_ffff);
    issue(OP_RECV, 16'd0, 16'd100, 32'd0);
    issue(OP_RECV, 16'd0, 16'd100, 32'd0);
    issue(OP_RECV, 16'd0, 16'd100, 32'd0);

    // zero maximum, widest limit
    configure(16'hffe0, 16'hffff);
    issue(OP_SEND, 16'd1, 16'hffff, 32'hdead_beef);
    issue(OP_RECV, 16'd0, 16'd0, 32'd0);
    issue(OP_RECV, 16'd0, 16'hffff, 32'd0);

    // maximum above depth, zero size limit
    configure(16'd31, 16'd0);
    issue(OP_SEND, 16'd5, 16'd0, 32'h8000_0001);
    issue(OP_SEND, 16'd5, 16'd1, 32'h8000_0001);
    issue(OP_RECV, 16'd0, 16'd0, 32'd0);
    issue(OP_QUERY, 16'd0, 16'd0, 32'd0);

    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: begin max_word = 16'd16; limit = 16'hffff; end
        1: begin max_word = 16'd1; limit = 16'd1; end
        2: begin max_word = 16'd31; limit = 16'd0; end
        3: begin max_word = 16'd0; limit = 16'd300; end
        4: begin max_word = 16'd10; limit = 16'd8192; end
        default: begin
          max_word = {11'($urandom()), 5'($urandom_range(0, 31))};
          case ($urandom_range(0, 3))
            0: limit = 16'd0;
            1: limit = 16'd1;
            2: limit = 16'hffff;
            default: limit = 16'($urandom_range(0, 65535));
          endcase
        end
      endcase
      configure(max_word, limit);
      send_weight = $urandom_range(30, 70);
      for (int n = 0; n < 122; n++) begin
        if (n % 30 == 0) gaps_on = (phase < 8) && ($urandom_range(0, 2) != 0);
        if (n == 61) send_weight = 100 - send_weight;
        random_item(send_weight);
      end
    end

    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (6) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/pmq_pkg.sv
hw/rtl/pmq_ctrl.sv
hw/rtl/pmq_dp.sv
hw/rtl/priority_message_queue.sv
sim/priority_message_queue_checker.sv
sim/priority_message_queue_tb.sv
